### rtl/tsc_pkg.sv
// Shared types, constants and helper functions of the text console scroll engine.
`default_nettype none

package tsc_pkg;

    // Screen geometry.
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int GRID_CELLS     = SCREEN_ROWS * SCREEN_COLUMNS;

    // Field widths of the request and response transactions.
    localparam int REQ_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int CUR_ROW_W = 5;
    localparam int CUR_COL_W = 7;

    // Internal widths that follow from the geometry.
    localparam int ADDR_W    = $clog2(GRID_CELLS);
    localparam int ROW_IDX_W = $clog2(SCREEN_ROWS);
    localparam int SWEEP_W   = $clog2(SCREEN_COLUMNS);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified command operations.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ
    } t_op;

    // One classified command as it travels through the queue.
    typedef struct packed {
        t_op                   op;
        logic [CHAR_W-1:0]     char_code;
        logic [CUR_ROW_W-1:0]  read_row;
        logic [CUR_COL_W-1:0]  read_col;
    } t_cmd;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PUT,
        BK_SWEEP,
        BK_READ,
        BK_RDOUT
    } t_back_state;

    // Map a screen row to a physical grid row through the top-row offset.
    function automatic logic [ROW_IDX_W-1:0] phys_row(
        input logic [ROW_IDX_W-1:0] top,
        input logic [CUR_ROW_W-1:0] row
    );
        logic [ROW_IDX_W+CUR_ROW_W:0] sum;
        sum = (ROW_IDX_W+CUR_ROW_W+1)'(top) + (ROW_IDX_W+CUR_ROW_W+1)'(row);
        if (sum >= (ROW_IDX_W+CUR_ROW_W+1)'(SCREEN_ROWS)) begin
            sum = sum - (ROW_IDX_W+CUR_ROW_W+1)'(SCREEN_ROWS);
        end
        return ROW_IDX_W'(sum);
    endfunction

    // Linear grid address of a physical row and a column.
    function automatic logic [ADDR_W-1:0] grid_addr(
        input logic [ROW_IDX_W-1:0] row,
        input logic [CUR_COL_W-1:0] col
    );
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col));
    endfunction

endpackage

`default_nettype wire

### rtl/tsc_in_if.sv
// Request channel interface of the text console scroll engine.
`default_nettype none

interface tsc_in_if;
    logic                              valid;
    logic                              ready;
    logic [tsc_pkg::REQ_W-1:0]         req_type;
    logic [tsc_pkg::CHAR_W-1:0]        char_code;
    logic [tsc_pkg::CUR_ROW_W-1:0]     read_row;
    logic [tsc_pkg::CUR_COL_W-1:0]     read_col;

    modport source (
        output valid, req_type, char_code, read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, req_type, char_code, read_row, read_col,
        output ready
    );
endinterface

`default_nettype wire

### rtl/tsc_out_if.sv
// Response channel interface of the text console scroll engine.
`default_nettype none

interface tsc_out_if;
    logic                              valid;
    logic                              ready;
    logic [tsc_pkg::CHAR_W-1:0]        cell_char;
    logic [tsc_pkg::CUR_ROW_W-1:0]     cursor_row;
    logic [tsc_pkg::CUR_COL_W-1:0]     cursor_col;

    modport source (
        output valid, cell_char, cursor_row, cursor_col,
        input  ready
    );
    modport sink (
        input  valid, cell_char, cursor_row, cursor_col,
        output ready
    );
endinterface

`default_nettype wire

### rtl/tsc_front.sv
// Front end: accepts requests, classifies them and queues the commands.
`default_nettype none

module tsc_front (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    tsc_in_if.sink         i_req,
    output tsc_pkg::t_cmd  o_cmd,
    output logic           o_cmd_valid,
    input  wire logic      i_cmd_pop
);

    tsc_pkg::t_cmd                   r_queue [tsc_pkg::QUEUE_DEPTH];
    logic [tsc_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [tsc_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [tsc_pkg::QCNT_W-1:0]      r_count;
    logic [tsc_pkg::QPTR_W-1:0]      n_wr_ptr;
    logic [tsc_pkg::QPTR_W-1:0]      n_rd_ptr;
    logic [tsc_pkg::QCNT_W-1:0]      n_count;
    tsc_pkg::t_cmd                   cls_cmd;
    logic                            push;
    logic                            pop;

    // Classify the incoming request into a command.
    always_comb begin
        cls_cmd.char_code = i_req.char_code;
        cls_cmd.read_row  = i_req.read_row;
        cls_cmd.read_col  = i_req.read_col;
        case (i_req.req_type)
            tsc_pkg::REQ_PUT: begin
                cls_cmd.op = (i_req.char_code == tsc_pkg::NEWLINE_CODE) ?
                             tsc_pkg::OP_NEWLINE : tsc_pkg::OP_PUT;
            end
            tsc_pkg::REQ_CLEAR: begin
                cls_cmd.op = tsc_pkg::OP_CLEAR;
            end
            tsc_pkg::REQ_READ: begin
                // A read outside the screen returns zero and touches nothing.
                if (i_req.read_row < tsc_pkg::CUR_ROW_W'(tsc_pkg::SCREEN_ROWS) &&
                    i_req.read_col < tsc_pkg::CUR_COL_W'(tsc_pkg::SCREEN_COLUMNS)) begin
                    cls_cmd.op = tsc_pkg::OP_READ;
                end else begin
                    cls_cmd.op = tsc_pkg::OP_NOP;
                end
            end
            default: begin
                cls_cmd.op = tsc_pkg::OP_NOP;
            end
        endcase
    end

    // Queue handshake.
    assign i_req.ready = (r_count != tsc_pkg::QCNT_W'(tsc_pkg::QUEUE_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == tsc_pkg::QPTR_W'(tsc_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + tsc_pkg::QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == tsc_pkg::QPTR_W'(tsc_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + tsc_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + tsc_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - tsc_pkg::QCNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cls_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/tsc_back.sv
// Back end: executes commands on the character grid and registers the response.
`default_nettype none

module tsc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tsc_pkg::t_cmd  i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_pop,
    tsc_out_if.source           o_rsp
);

    // Character grid.
    logic [tsc_pkg::CHAR_W-1:0]      mem [tsc_pkg::GRID_CELLS];
    logic                            mem_we;
    logic [tsc_pkg::ADDR_W-1:0]      mem_waddr;
    logic [tsc_pkg::CHAR_W-1:0]      mem_wdata;
    logic [tsc_pkg::ADDR_W-1:0]      mem_raddr;
    logic [tsc_pkg::CHAR_W-1:0]      r_rdata;

    // Sequencer and console state.
    tsc_pkg::t_back_state            r_state;
    tsc_pkg::t_back_state            n_state;
    logic [tsc_pkg::ROW_IDX_W-1:0]   r_top;
    logic [tsc_pkg::ROW_IDX_W-1:0]   n_top;
    logic [tsc_pkg::CUR_ROW_W-1:0]   r_crow;
    logic [tsc_pkg::CUR_ROW_W-1:0]   n_crow;
    logic [tsc_pkg::CUR_COL_W-1:0]   r_ccol;
    logic [tsc_pkg::CUR_COL_W-1:0]   n_ccol;
    logic [tsc_pkg::SCREEN_ROWS-1:0] r_row_valid;
    logic [tsc_pkg::SCREEN_ROWS-1:0] n_row_valid;
    logic [tsc_pkg::SWEEP_W-1:0]     r_sweep_col;
    logic [tsc_pkg::SWEEP_W-1:0]     n_sweep_col;
    logic [tsc_pkg::CHAR_W-1:0]      r_char;
    logic [tsc_pkg::CHAR_W-1:0]      n_char;
    logic [tsc_pkg::ROW_IDX_W-1:0]   r_rd_row;
    logic [tsc_pkg::ROW_IDX_W-1:0]   n_rd_row;
    logic [tsc_pkg::CUR_COL_W-1:0]   r_rd_col;
    logic [tsc_pkg::CUR_COL_W-1:0]   n_rd_col;

    // Response register.
    logic                            r_out_valid;
    logic [tsc_pkg::CHAR_W-1:0]      r_out_cell;
    logic [tsc_pkg::CUR_ROW_W-1:0]   r_out_row;
    logic [tsc_pkg::CUR_COL_W-1:0]   r_out_col;
    logic                            emit;
    logic [tsc_pkg::CHAR_W-1:0]      emit_cell;

    logic                            out_free;
    logic                            take;
    logic [tsc_pkg::ROW_IDX_W-1:0]   put_row;
    logic                            sweep_last;
    logic [tsc_pkg::CUR_ROW_W-1:0]   w_row;
    logic [tsc_pkg::CUR_COL_W-1:0]   w_col;

    // A command is taken only when the response register will be free for it.
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign take       = (r_state == tsc_pkg::BK_IDLE) && i_cmd_valid && out_free;
    assign o_cmd_pop  = take;
    assign put_row    = tsc_pkg::phys_row(r_top, r_crow);
    assign sweep_last = (r_sweep_col == tsc_pkg::SWEEP_W'(tsc_pkg::SCREEN_COLUMNS - 1));
    assign mem_raddr  = tsc_pkg::grid_addr(r_rd_row, r_rd_col);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsc_pkg::BK_IDLE: begin
                if (take) begin
                    case (i_cmd.op)
                        tsc_pkg::OP_PUT:  n_state = tsc_pkg::BK_PUT;
                        tsc_pkg::OP_READ: n_state = tsc_pkg::BK_READ;
                        default:          n_state = tsc_pkg::BK_IDLE;
                    endcase
                end
            end
            tsc_pkg::BK_PUT: begin
                n_state = r_row_valid[put_row] ? tsc_pkg::BK_IDLE : tsc_pkg::BK_SWEEP;
            end
            tsc_pkg::BK_SWEEP: begin
                n_state = sweep_last ? tsc_pkg::BK_PUT : tsc_pkg::BK_SWEEP;
            end
            tsc_pkg::BK_READ: begin
                n_state = tsc_pkg::BK_RDOUT;
            end
            tsc_pkg::BK_RDOUT: begin
                n_state = tsc_pkg::BK_IDLE;
            end
            default: begin
                n_state = tsc_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb begin
        n_top       = r_top;
        n_crow      = r_crow;
        n_ccol      = r_ccol;
        n_row_valid = r_row_valid;
        n_sweep_col = r_sweep_col;
        n_char      = r_char;
        n_rd_row    = r_rd_row;
        n_rd_col    = r_rd_col;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        emit        = 1'b0;
        emit_cell   = '0;
        w_row       = r_crow;
        w_col       = r_ccol;
        case (r_state)
            tsc_pkg::BK_IDLE: begin
                if (take) begin
                    case (i_cmd.op)
                        tsc_pkg::OP_PUT: begin
                            // Wrap past the last column, then scroll past the last row.
                            if (r_ccol >= tsc_pkg::CUR_COL_W'(tsc_pkg::SCREEN_COLUMNS)) begin
                                w_col = '0;
                                if (r_crow < tsc_pkg::CUR_ROW_W'(tsc_pkg::SCREEN_ROWS)) begin
                                    w_row = r_crow + tsc_pkg::CUR_ROW_W'(1);
                                end
                            end
                            if (w_row >= tsc_pkg::CUR_ROW_W'(tsc_pkg::SCREEN_ROWS)) begin
                                // The top row is dropped and comes back as the bottom row.
                                n_row_valid[r_top] = 1'b0;
                                n_top = (r_top == tsc_pkg::ROW_IDX_W'(tsc_pkg::SCREEN_ROWS - 1)) ?
                                        '0 : r_top + tsc_pkg::ROW_IDX_W'(1);
                                w_row = tsc_pkg::CUR_ROW_W'(tsc_pkg::SCREEN_ROWS - 1);
                            end
                            n_crow      = w_row;
                            n_ccol      = w_col;
                            n_char      = i_cmd.char_code;
                            n_sweep_col = '0;
                        end
                        tsc_pkg::OP_NEWLINE: begin
                            n_ccol = '0;
                            if (r_crow < tsc_pkg::CUR_ROW_W'(tsc_pkg::SCREEN_ROWS)) begin
                                n_crow = r_crow + tsc_pkg::CUR_ROW_W'(1);
                            end
                            emit = 1'b1;
                        end
                        tsc_pkg::OP_CLEAR: begin
                            n_row_valid = '0;
                            n_top       = '0;
                            n_crow      = '0;
                            n_ccol      = '0;
                            emit        = 1'b1;
                        end
                        tsc_pkg::OP_READ: begin
                            n_rd_row = tsc_pkg::phys_row(r_top, i_cmd.read_row);
                            n_rd_col = i_cmd.read_col;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            tsc_pkg::BK_PUT: begin
                // Store into a clean row; a stale row is swept to zero first.
                if (r_row_valid[put_row]) begin
                    mem_we    = 1'b1;
                    mem_waddr = tsc_pkg::grid_addr(put_row, r_ccol);
                    mem_wdata = r_char;
                    n_ccol    = r_ccol + tsc_pkg::CUR_COL_W'(1);
                    emit      = 1'b1;
                end
            end
            tsc_pkg::BK_SWEEP: begin
                mem_we      = 1'b1;
                mem_waddr   = tsc_pkg::grid_addr(put_row, tsc_pkg::CUR_COL_W'(r_sweep_col));
                mem_wdata   = '0;
                n_sweep_col = sweep_last ? '0 : r_sweep_col + tsc_pkg::SWEEP_W'(1);
                if (sweep_last) begin
                    n_row_valid[put_row] = 1'b1;
                end
            end
            tsc_pkg::BK_RDOUT: begin
                emit      = 1'b1;
                emit_cell = r_row_valid[r_rd_row] ? r_rdata : '0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsc_pkg::BK_IDLE;
            r_top       <= '0;
            r_crow      <= '0;
            r_ccol      <= '0;
            r_row_valid <= '0;
            r_sweep_col <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_crow      <= n_crow;
            r_ccol      <= n_ccol;
            r_row_valid <= n_row_valid;
            r_sweep_col <= n_sweep_col;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_char   <= n_char;
        r_rd_row <= n_rd_row;
        r_rd_col <= n_rd_col;
        if (emit) begin
            r_out_cell <= emit_cell;
            r_out_row  <= n_crow;
            r_out_col  <= n_ccol;
        end
    end

    // Grid memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cell_char  = r_out_cell;
    assign o_rsp.cursor_row = r_out_row;
    assign o_rsp.cursor_col = r_out_col;

endmodule

`default_nettype wire

### rtl/text_console_scroll_engine.sv
// Top level of the text console scroll engine.
//
// Requests arrive on i_req (valid/ready); each transaction is a put-char, a
// clear-screen or a cell read. Every request yields exactly one transaction
// on o_rsp carrying the cell character (reads only, else zero) and the cursor
// position after the request.
// A stored character whose target row is stale first has that row swept to
// zero through the single write port of the grid memory, one column at a
// time, and then the row is revisited to store the character. That sweep
// happens on the first write to a row after reset or a clear and after each
// scroll drops it. The back-end sequencer takes a new command only when it is
// idle and the response register will be free for it, so it finishes one
// command before it takes the next.
// A two-entry command queue separates the request side from the sequencer,
// so requests keep being accepted until it is full while a response waits on
// a stalled receiver; the response register holds its value until it is taken.
// Reset is synchronous and active low. It clears the cursor, the scroll
// offset and the per-row clean flags, so the screen reads as zero at once.
`default_nettype none

module text_console_scroll_engine (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tsc_in_if.sink     i_req,
    tsc_out_if.source  o_rsp
);

    tsc_pkg::t_cmd  cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    // Request intake and classification.
    tsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Command execution and response register.
    tsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

### rtl/tsc_checker.sv
// Port-level checks of the text console scroll engine, bound to the top level.
`default_nettype none

module tsc_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [tsc_pkg::CHAR_W-1:0]       i_cell_char,
    input wire logic [tsc_pkg::CUR_ROW_W-1:0]    i_cursor_row,
    input wire logic [tsc_pkg::CUR_COL_W-1:0]    i_cursor_col
);

    logic [3:0] r_pending;

    // Count requests that have been accepted but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(i_in_valid && i_in_ready)
                                   - 4'(i_out_valid && i_out_ready);
        end
    end

    // A stalled response keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_cell_char) && $stable(i_cursor_row) &&
            $stable(i_cursor_col))
        else $error("response changed while stalled");

    // No response appears without an outstanding request.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != '0)
        else $error("response without a pending request");

    // The cursor stays within the screen plus one past the last row and column.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cursor_row <= tsc_pkg::CUR_ROW_W'(tsc_pkg::SCREEN_ROWS) &&
                        i_cursor_col <= tsc_pkg::CUR_COL_W'(tsc_pkg::SCREEN_COLUMNS))
        else $error("cursor out of range");

    // The row below the screen is only reached by a newline, which homes the column.
    a_row_sat_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_cursor_row == tsc_pkg::CUR_ROW_W'(tsc_pkg::SCREEN_ROWS) |->
            i_cursor_col == '0)
        else $error("cursor column nonzero on the row below the screen");

endmodule

bind text_console_scroll_engine tsc_checker u_tsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_cell_char  (o_rsp.cell_char),
    .i_cursor_row (o_rsp.cursor_row),
    .i_cursor_col (o_rsp.cursor_col)
);

`default_nettype wire

### sim/tsc_reply_checker.sv
// Checker that predicts each console response and compares it with the block's output.
`timescale 1ns / 100ps

module tsc_reply_checker
    import tsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tsc_in_if    i_req_mon,
    tsc_out_if   i_rsp_mon,
    output int   o_error_count,
    output int   o_pending
);

    // One expected response transaction.
    typedef struct packed {
        logic [CHAR_W-1:0]    cell_char;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CUR_COL_W-1:0] cursor_col;
    } console_reply_t;

    // Shadow copy of the console: physical grid, scroll offset and cursor.
    logic [CHAR_W-1:0] screen_cells [GRID_CELLS];
    int unsigned       top_row_q;
    int unsigned       cursor_row_q;
    int unsigned       cursor_col_q;

    console_reply_t    awaited_replies [$];
    int                error_count = 0;
    int                pending_count = 0;

    assign o_error_count = error_count;
    assign o_pending     = pending_count;

    // Print one line per mismatch and keep count.
    task automatic report_error(input string msg);
        error_count = error_count + 1;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Blank the whole grid and home the cursor and the offset.
    function automatic void wipe_console();
        for (int i = 0; i < GRID_CELLS; i++) begin
            screen_cells[i] = '0;
        end
        top_row_q    = 0;
        cursor_row_q = 0;
        cursor_col_q = 0;
    endfunction

    // Put one character: newline, column wrap, scroll, then store.
    function automatic void store_character(input logic [CHAR_W-1:0] ch);
        int unsigned line;
        if (ch == NEWLINE_CODE) begin
            cursor_col_q = 0;
            if (cursor_row_q < SCREEN_ROWS) begin
                cursor_row_q++;
            end
            return;
        end
        if (cursor_col_q >= SCREEN_COLUMNS) begin
            cursor_col_q = 0;
            if (cursor_row_q < SCREEN_ROWS) begin
                cursor_row_q++;
            end
        end
        // The row shown at the top is blanked and becomes the new bottom row.
        if (cursor_row_q >= SCREEN_ROWS) begin
            for (int c = 0; c < SCREEN_COLUMNS; c++) begin
                screen_cells[top_row_q * SCREEN_COLUMNS + c] = '0;
            end
            top_row_q    = (top_row_q + 1) % SCREEN_ROWS;
            cursor_row_q = SCREEN_ROWS - 1;
        end
        line = (top_row_q + cursor_row_q) % SCREEN_ROWS;
        screen_cells[line * SCREEN_COLUMNS + cursor_col_q] = ch;
        cursor_col_q++;
    endfunction

    // Apply one request to the shadow console and return the response it yields.
    function automatic console_reply_t predict_reply(
        input logic [REQ_W-1:0]     kind,
        input logic [CHAR_W-1:0]    ch,
        input logic [CUR_ROW_W-1:0] row,
        input logic [CUR_COL_W-1:0] col
    );
        console_reply_t reply;
        int unsigned    line;
        reply.cell_char = '0;
        case (kind)
            REQ_PUT: begin
                store_character(ch);
            end
            REQ_CLEAR: begin
                wipe_console();
            end
            REQ_READ: begin
                if (row < SCREEN_ROWS && col < SCREEN_COLUMNS) begin
                    line = (top_row_q + row) % SCREEN_ROWS;
                    reply.cell_char = screen_cells[line * SCREEN_COLUMNS + col];
                end
            end
            default: begin
            end
        endcase
        reply.cursor_row = CUR_ROW_W'(cursor_row_q);
        reply.cursor_col = CUR_COL_W'(cursor_col_q);
        return reply;
    endfunction

    // Queue a prediction for every accepted request and check every accepted response.
    always @(posedge i_clk) begin : track_replies
        console_reply_t want;
        if (!i_rst_n) begin
            wipe_console();
            awaited_replies.delete();
        end else begin
            if (i_req_mon.valid === 1'b1 && i_req_mon.ready === 1'b1) begin
                awaited_replies.push_back(predict_reply(i_req_mon.req_type,
                    i_req_mon.char_code, i_req_mon.read_row, i_req_mon.read_col));
            end
            if (i_rsp_mon.valid === 1'b1 && i_rsp_mon.ready === 1'b1) begin
                if (awaited_replies.size() == 0) begin
                    report_error("response transaction with no request outstanding");
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_rsp_mon.cell_char !== want.cell_char) begin
                        report_error($sformatf("cell_char got %0h, expected %0h",
                            i_rsp_mon.cell_char, want.cell_char));
                    end
                    if (i_rsp_mon.cursor_row !== want.cursor_row) begin
                        report_error($sformatf("cursor_row got %0d, expected %0d",
                            i_rsp_mon.cursor_row, want.cursor_row));
                    end
                    if (i_rsp_mon.cursor_col !== want.cursor_col) begin
                        report_error($sformatf("cursor_col got %0d, expected %0d",
                            i_rsp_mon.cursor_col, want.cursor_col));
                    end
                end
            end
        end
        pending_count <= awaited_replies.size();
    end

endmodule

### sim/tb_text_console_scroll_engine.sv
// Testbench top: clock, reset, request and response traffic, and the final verdict.
`timescale 1ns / 100ps

module tb_text_console_scroll_engine;
    import tsc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 450;
    localparam int CALM_ITEMS   = 60;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    logic quiet_tail = 1'b0;
    int   items_sent = 0;
    int   error_count;
    int   replies_pending;

    tsc_in_if  req_if ();
    tsc_out_if rsp_if ();

    text_console_scroll_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    tsc_reply_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_mon     (req_if),
        .i_rsp_mon     (rsp_if),
        .o_error_count (error_count),
        .o_pending     (replies_pending)
    );

    // 2 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offer one request transaction, after an optional idle burst, and wait until taken.
    task automatic send_request(
        input logic [REQ_W-1:0]     kind,
        input logic [CHAR_W-1:0]    ch,
        input logic [CUR_ROW_W-1:0] row,
        input logic [CUR_COL_W-1:0] col
    );
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= kind;
        req_if.char_code <= ch;
        req_if.read_row  <= row;
        req_if.read_col  <= col;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering and hold off until every response has come back.
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (replies_pending != 0) @(posedge i_clk);
    endtask

    // Response side: ready stalls in short bursts, with calm stretches between.
    initial begin : rsp_ready_driver
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Request side: directed cases, then random traffic shaped as text and scrolling.
    initial begin : stimulus
        int               pick;
        int               run_len;
        logic [CHAR_W-1:0] ch;

        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_PUT;
        req_if.char_code = '0;
        req_if.read_row  = '0;
        req_if.read_col  = '0;
        i_rst_n          = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty screen, byte extremes, newline, read limits, unused code, clear.
        send_request(REQ_READ, 8'h00, 5'd0, 7'd0);
        send_request(REQ_PUT, 8'h41, 5'd0, 7'd0);
        send_request(REQ_PUT, 8'h00, 5'd0, 7'd0);
        send_request(REQ_PUT, 8'hFF, 5'd31, 7'd127);
        send_request(REQ_READ, 8'hFF, 5'd0, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd0, 7'd2);
        send_request(REQ_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd24, 7'd79);
        send_request(REQ_READ, 8'h00, 5'd25, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd0, 7'd80);
        send_request(REQ_READ, 8'h00, 5'd31, 7'd127);
        send_request(REQ_UNUSED, 8'hFF, 5'd31, 7'd127);
        send_request(REQ_UNUSED, 8'h00, 5'd0, 7'd0);
        send_request(REQ_PUT, 8'h55, 5'd1, 7'd2);
        send_request(REQ_CLEAR, 8'hFF, 5'd31, 7'd127);
        send_request(REQ_READ, 8'h00, 5'd0, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd1, 7'd0);
        send_request(REQ_PUT, 8'h80, 5'd0, 7'd0);
        send_request(REQ_PUT, 8'h7F, 5'd0, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd0, 7'd0);
        send_request(REQ_READ, 8'h00, 5'd0, 7'd1);
        wait_for_drain();

        // Random traffic in segments: text lines, newline runs, reads, noise, rare clears.
        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
                quiet_tail <= 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // A line of text, long enough at times to wrap past the last column.
                run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                                      : $urandom_range(1, 30);
                repeat (run_len) begin
                    if ($urandom_range(0, 5) == 0) begin
                        send_request(REQ_READ, 8'($urandom),
                            5'($urandom_range(0, SCREEN_ROWS - 1)),
                            7'($urandom_range(0, SCREEN_COLUMNS - 1)));
                    end else begin
                        ch = 8'($urandom);
                        if (ch == NEWLINE_CODE) begin
                            ch = 8'h20;
                        end
                        send_request(REQ_PUT, ch, 5'($urandom), 7'($urandom));
                    end
                end
                if ($urandom_range(0, 1) == 0) begin
                    send_request(REQ_PUT, NEWLINE_CODE, 5'($urandom), 7'($urandom));
                end
            end else if (pick < 65) begin
                // Newline run that drives the cursor to the bottom and into saturation.
                repeat ($urandom_range(1, 30)) begin
                    send_request(REQ_PUT, NEWLINE_CODE, 5'($urandom), 7'($urandom));
                end
                send_request(REQ_PUT, 8'($urandom_range(33, 126)), 5'($urandom),
                    7'($urandom));
            end else if (pick < 85) begin
                // Cell reads, mostly on screen.
                repeat ($urandom_range(1, 10)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_request(REQ_READ, 8'($urandom), 5'($urandom), 7'($urandom));
                    end else begin
                        send_request(REQ_READ, 8'($urandom),
                            5'($urandom_range(0, SCREEN_ROWS - 1)),
                            7'($urandom_range(0, SCREEN_COLUMNS - 1)));
                    end
                end
            end else if (pick < 97) begin
                // Noise: unused code, raw bytes and off-screen reads.
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 2))
                        0: send_request(REQ_UNUSED, 8'($urandom), 5'($urandom),
                               7'($urandom));
                        1: send_request(REQ_PUT, 8'($urandom), 5'($urandom),
                               7'($urandom));
                        default: send_request(REQ_READ, 8'($urandom),
                               5'($urandom_range(SCREEN_ROWS, 31)), 7'($urandom));
                    endcase
                end
            end else begin
                send_request(REQ_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
            end
        end

        // Let every response arrive, then watch a little longer for strays.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
